// File: hdl/miq_pkg.sv
// miq_pkg: sizes, operation and status codes and ring arithmetic for the
// middle-insert indexed queue. Used by the top level and its checker.
// No dependencies.
package miq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;

    // field widths of the transaction ports
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;

    // each ring keeps two spare slots beyond half the capacity
    localparam int RING_SLOTS = CAPACITY / 2 + 2;
    localparam int ADDR_W     = $clog2(RING_SLOTS);
    localparam int CNT_W      = $clog2(RING_SLOTS + 1);
    localparam int TOT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (TOT_W > INDEX_W) ? TOT_W : INDEX_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK   = 2'd0,
        OP_PUSH_FRONT  = 2'd1,
        OP_PUSH_MIDDLE = 2'd2,
        OP_GET         = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_READ    = 4'b0010,
        S_MOVE_RD = 4'b0100,
        S_MOVE_WR = 4'b1000
    } state_t;

    // base + off modulo the ring size, both operands below the ring size
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W+1)'(RING_SLOTS))
        begin
            sum = sum - (ADDR_W+1)'(RING_SLOTS);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] base);
        return (base == '0) ? ADDR_W'(RING_SLOTS - 1) : base - 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] base);
        return (base == ADDR_W'(RING_SLOTS - 1)) ? '0 : base + 1'b1;
    endfunction

endpackage

// File: hdl/miq_ram.sv
// miq_ram: generic single-clock ram, one write port and one read port,
// read data registered and held while no read is issued.
// No dependencies.
module miq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/middle_insert_indexed_queue.sv
// middle_insert_indexed_queue: teque with push at back, front and middle and
// indexed get. Depends on miq_pkg and miq_ram.
//
// Usage: the input channel (in_valid / in_stall) carries operation, value and
// index; the output channel (out_valid / out_stall) carries read_value and
// status. A get always returns one transaction: the element at index with
// status ok, or zero with status index-out-of-range. A push returns nothing
// when it succeeds and zero with status queue-full when the queue already
// holds CAPACITY elements.
// Sequencing: an in-range get stalls the input in S_READ; the ring read is
// captured at the accepting edge and registered as the result once the output
// is free. A push moving an element between the halves then passes S_MOVE_RD
// and S_MOVE_WR (ring read then ring write on the ram ports); refused pushes
// and out-of-range gets show their result from the accepting edge.
// The state sits in two 514-entry rings; the move read is issued the cycle
// after the push write, so the same entry is never read and written at once.
// Reset empties both halves; ring contents are not cleared and need no
// clearing pass. While the receiver stalls, the result holds in the output
// register and in_stall stays high until it is taken.
module middle_insert_indexed_queue
    import miq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [DATA_W-1:0]   value,
    input  logic [INDEX_W-1:0]         index,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   read_value,
    output logic [STATUS_W-1:0]        status
);

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     f_head_reg, f_head_next;
    logic [CNT_W-1:0]      f_cnt_reg, f_cnt_next;
    logic [ADDR_W-1:0]     s_head_reg, s_head_next;
    logic [CNT_W-1:0]      s_cnt_reg, s_cnt_next;
    logic                  sel_reg, sel_next;
    logic [ADDR_W-1:0]     src_addr_reg, src_addr_next;
    logic [ADDR_W-1:0]     dst_addr_reg, dst_addr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     read_value_reg, read_value_next;
    status_t               status_reg, status_next;

    // ram ports
    logic                  f_we, f_re, s_we, s_re;
    logic [ADDR_W-1:0]     f_waddr, f_raddr, s_waddr, s_raddr;
    logic [VALUE_BITS-1:0] f_wdata, s_wdata, f_rdata, s_rdata, rdata;

    logic                  accept, out_free, full, in_range, in_first;
    op_t                   op;
    logic [TOT_W-1:0]      total;
    logic [CMP_W-1:0]      idx_ext;
    logic [ADDR_W-1:0]     get_addr;
    logic                  push_ring, move_need;
    logic [ADDR_W-1:0]     push_addr;
    logic [ADDR_W-1:0]     f_head1, s_head1, f_head2, s_head2, mv_src, mv_dst;
    logic [CNT_W-1:0]      f1, s1, f2, s2;
    logic                  mv_sel;
    logic [VALUE_BITS-1:0] push_value;

    assign op         = op_t'(operation);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign total      = TOT_W'(f_cnt_reg) + TOT_W'(s_cnt_reg);
    assign full       = total >= TOT_W'(CAPACITY);
    assign idx_ext    = CMP_W'(index);
    assign in_range   = idx_ext < CMP_W'(total);
    assign in_first   = idx_ext < CMP_W'(f_cnt_reg);
    assign get_addr   = in_first ? ring_add(f_head_reg, ADDR_W'(idx_ext))
                                 : ring_add(s_head_reg, ADDR_W'(idx_ext - CMP_W'(f_cnt_reg)));
    assign push_value = VALUE_BITS'($unsigned(value));
    assign rdata      = sel_reg ? s_rdata : f_rdata;

    // push placement, then the one-element rebalance on the new counts
    always_comb
    begin
        f_head1   = f_head_reg;
        s_head1   = s_head_reg;
        f1        = f_cnt_reg;
        s1        = s_cnt_reg;
        push_ring = 1'b1;
        push_addr = ring_add(s_head_reg, ADDR_W'(s_cnt_reg));
        case (op)
            OP_PUSH_BACK:
            begin
                s1 = s_cnt_reg + 1'b1;
            end
            OP_PUSH_FRONT:
            begin
                push_ring = 1'b0;
                f_head1   = ring_dec(f_head_reg);
                push_addr = f_head1;
                f1        = f_cnt_reg + 1'b1;
            end
            OP_PUSH_MIDDLE:
            begin
                s_head1   = ring_dec(s_head_reg);
                push_addr = s_head1;
                s1        = s_cnt_reg + 1'b1;
            end
            default:
            begin
                push_ring = 1'b1;
            end
        endcase

        f_head2   = f_head1;
        s_head2   = s_head1;
        f2        = f1;
        s2        = s1;
        move_need = 1'b0;
        mv_sel    = 1'b0;
        mv_src    = '0;
        mv_dst    = '0;
        if (s1 > f1)
        begin
            // head of the second half goes to the tail of the first
            move_need = 1'b1;
            mv_sel    = 1'b1;
            mv_src    = s_head1;
            s_head2   = ring_inc(s_head1);
            s2        = s1 - 1'b1;
            mv_dst    = ring_add(f_head1, ADDR_W'(f1));
            f2        = f1 + 1'b1;
        end
        else if ((CNT_W+1)'(f1) > (CNT_W+1)'(s1) + 1'b1)
        begin
            // tail of the first half goes to the head of the second
            move_need = 1'b1;
            mv_sel    = 1'b0;
            f2        = f1 - 1'b1;
            mv_src    = ring_add(f_head1, ADDR_W'(f2));
            s_head2   = ring_dec(s_head1);
            mv_dst    = s_head2;
            s2        = s1 + 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        f_head_next     = f_head_reg;
        f_cnt_next      = f_cnt_reg;
        s_head_next     = s_head_reg;
        s_cnt_next      = s_cnt_reg;
        sel_next        = sel_reg;
        src_addr_next   = src_addr_reg;
        dst_addr_next   = dst_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        f_we    = 1'b0;
        f_waddr = push_addr;
        f_wdata = push_value;
        f_re    = 1'b0;
        f_raddr = get_addr;
        s_we    = 1'b0;
        s_waddr = push_addr;
        s_wdata = push_value;
        s_re    = 1'b0;
        s_raddr = get_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_GET)
                    begin
                        if (in_range)
                        begin
                            f_re       = in_first;
                            s_re       = !in_first;
                            sel_next   = !in_first;
                            state_next = S_READ;
                        end
                        else
                        begin
                            out_valid_next  = 1'b1;
                            read_value_next = '0;
                            status_next     = ST_RANGE;
                        end
                    end
                    else if (full)
                    begin
                        out_valid_next  = 1'b1;
                        read_value_next = '0;
                        status_next     = ST_FULL;
                    end
                    else
                    begin
                        f_we          = !push_ring;
                        s_we          = push_ring;
                        f_head_next   = f_head2;
                        s_head_next   = s_head2;
                        f_cnt_next    = f2;
                        s_cnt_next    = s2;
                        sel_next      = mv_sel;
                        src_addr_next = mv_src;
                        dst_addr_next = mv_dst;
                        if (move_need)
                        begin
                            state_next = S_MOVE_RD;
                        end
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = DATA_W'(rdata);
                    status_next     = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_MOVE_RD:
            begin
                f_raddr    = src_addr_reg;
                s_raddr    = src_addr_reg;
                f_re       = !sel_reg;
                s_re       = sel_reg;
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                f_waddr    = dst_addr_reg;
                s_waddr    = dst_addr_reg;
                f_wdata    = rdata;
                s_wdata    = rdata;
                f_we       = sel_reg;
                s_we       = !sel_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            f_head_reg    <= '0;
            f_cnt_reg     <= '0;
            s_head_reg    <= '0;
            s_cnt_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            f_head_reg    <= f_head_next;
            f_cnt_reg     <= f_cnt_next;
            s_head_reg    <= s_head_next;
            s_cnt_reg     <= s_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg        <= sel_next;
        src_addr_reg   <= src_addr_next;
        dst_addr_reg   <= dst_addr_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    miq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (RING_SLOTS)
    ) u_first_ring (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    miq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (RING_SLOTS)
    ) u_second_ring (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule

// File: hdl/miq_checker.sv
// miq_checker: port-level assertions for middle_insert_indexed_queue,
// attached by the bind below. Depends on miq_pkg.
module miq_checker
    import miq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [OP_W-1:0]          operation,
    input logic signed [DATA_W-1:0] value,
    input logic [INDEX_W-1:0]       index,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [DATA_W-1:0] read_value,
    input logic [STATUS_W-1:0]      status
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
        else $error("stalled result changed");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_RANGE || status == ST_FULL) |-> read_value == '0)
        else $error("error result with nonzero value");

    // a get either answers at once or keeps the input stalled for the ram read
    a_get_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_GET |=> in_stall || out_valid)
        else $error("get gave neither a result nor a stall");

    // a stalled output blocks new input
    a_out_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while result stalled");

endmodule

bind middle_insert_indexed_queue miq_checker u_miq_checker (.*);
